@@ design/assert_macros.svh @@
// Assertion macros shared by the pose averaging design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ design/pmpma_pkg.sv @@
// Shared types and constants for the per-marker pose averager
package pmpma_pkg;
   localparam int MARKERS    = 8;
   localparam int WINDOW_MAX = 16;
   localparam int ID_W       = 3;
   localparam int MK_W       = (MARKERS > 1) ? $clog2(MARKERS) : 1;
   localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int ADDR_W     = MK_W + SLOT_W;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 20;
   localparam int ANG_W      = 16;
   localparam int WORD_W     = 16;
   localparam int SUMP_W     = POS_W + SLOT_W + 1;
   localparam int SUMA_W     = ANG_W + SLOT_W + 1;
   localparam int PROD_W     = SUMA_W + 23;
   localparam int QDIV_W     = PROD_W;
   localparam logic [22:0] RAD_TO_DEG_Q16 = 23'd3754936;
   localparam logic [0:0] CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [0:0] CSR_INVALID_WORD  = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_WRITE = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;      // capture input beat
      logic write;     // write sample, update slot and count
      logic sum_clr;   // clear accumulators
      logic sum_step;  // add the slot at the read index
      logic mul;       // angle sum times rad-to-deg
      logic div_start; // load dividers
      logic div_step;  // one quotient bit
      logic fin;       // form result words
   } cmd_type;

   typedef struct packed {
      logic             eligible;  // detected and id in range
      logic             full;      // window filled after write
      logic             last_slot; // summing the last slot
      logic             div_done;
   } sts_type;
endpackage

@@ design/per_marker_pose_moving_average.sv @@
// Top level of the per-marker pose moving average
// Usage: one observation beat on req_ (tdata: marker_id, detected, x_pos,
// y_pos, angle_rad from bit 0 up) yields exactly one result beat on rsp_
// (tdata: out_marker, x_word, y_word, angle_deg_word, valid_res).
// A detected marker's sample is stored in its window; once the window is
// full the result carries -mean x, mean y and mean angle in degrees.
// Otherwise all three words carry the invalid word.
// An absent or unfilled marker skips summing and division; a full window
// (length clamped to 1..16) is summed and then passes through the three
// restoring dividers (one quotient bit per cycle, 44 bits).
// One item is in flight at a time; the next beat is taken as soon as
// the result has been taken or is being taken.
// Reset clears write slots, fill counts and registers (window_length 4,
// invalid_word 0xFFFF); window contents stay undefined until written.
// A stalled receiver holds the result and blocks new input.
// csr_ writes land on the clock edge with csr_we high; write only idle.
module per_marker_pose_moving_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // marker_id, detected, x_pos, y_pos, angle_rad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_marker, x_word, y_word, angle_deg_word, valid_res
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import pmpma_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pmpma_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   pmpma_dp u_dp (
      .clock(clock), .reset(reset), .req_tdata(req_tdata), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts),
      .rsp_tdata(rsp_tdata)
   );
endmodule

@@ design/pmpma_ctrl.sv @@
// Sequencer for the pose averager
module pmpma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  pmpma_pkg::sts_type sts,
   output pmpma_pkg::cmd_type cmd
);
   import pmpma_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   // input is taken once the previous result is gone or leaving
   assign req_tready = (state_ff == ST_IDLE) && (!rv_ff || rsp_tready);
   assign rsp_tvalid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rv_in = rv_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = sts.eligible;
            cmd.sum_clr = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!(sts.eligible && sts.full)) begin
               state_in = ST_FIN;
            end else begin
               cmd.sum_step = 1'b1;
               if (sts.last_slot) state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   `ASSERT_IMPL(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `ASSERT_IMPL(a_fin_free, clock, reset, (state_ff == ST_FIN) |-> (!rv_ff || rsp_tready),
                "result overwritten")
   `ASSERT_IMPL(a_load_idle, clock, reset, cmd.load |=> (state_ff == ST_WRITE),
                "load without write step")
endmodule

@@ design/pmpma_dp.sv @@
// Sample windows, summing and division datapath
module pmpma_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [63:0]                     req_tdata,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [15:0]                     csr_wdata,
   input  pmpma_pkg::cmd_type              cmd,
   output pmpma_pkg::sts_type              sts,
   output logic [55:0]                     rsp_tdata
);
   import pmpma_pkg::*;

   logic [LEN_W-1:0]  wlen_ff;
   logic [WORD_W-1:0] inv_ff;
   logic [SLOT_W-1:0] slot_ff [MARKERS];
   logic [CNT_W-1:0]  cnt_ff  [MARKERS];
   logic [POS_W-1:0]  xmem [MARKERS*WINDOW_MAX];
   logic [POS_W-1:0]  ymem [MARKERS*WINDOW_MAX];
   logic [ANG_W-1:0]  amem [MARKERS*WINDOW_MAX];

   logic [ID_W-1:0]   id_ff;
   logic              det_ff;
   logic [POS_W-1:0]  x_ff, y_ff;
   logic [ANG_W-1:0]  a_ff;
   logic              elig, full_ff;
   logic [MK_W-1:0]   mk;
   logic [CNT_W-1:0]  len;
   logic [SLOT_W-1:0] lenm1, pos;
   logic [CNT_W-1:0]  cnt_next;
   logic [SLOT_W:0]   ridx_ff;
   logic              rd_en_ff;
   logic [POS_W-1:0]  xr_ff, yr_ff;
   logic [ANG_W-1:0]  ar_ff;
   logic signed [SUMP_W-1:0] xs_ff, ys_ff;
   logic signed [SUMA_W-1:0] as_ff;
   logic signed [PROD_W-1:0] prod_ff;
   // three restoring dividers sharing one bit counter
   logic [QDIV_W-1:0] rx_ff, ry_ff, ra_ff;
   logic [QDIV_W-1:0] nx_ff, ny_ff, na_ff;
   logic [QDIV_W-1:0] dpos_ff, dang_ff;
   logic              sx_ff, sy_ff, sa_ff;
   logic [6:0]        bit_ff;
   logic [15:0]       xw_ff, yw_ff, aw_ff;
   logic              vres_ff;
   logic [QDIV_W-1:0] rxs, rys, ras;

   assign elig = det_ff && ({{(32-ID_W){1'b0}}, id_ff} < MARKERS);
   assign mk   = MK_W'(id_ff);
   always_comb begin
      if (wlen_ff == '0) len = CNT_W'(1);
      else if ({{(32-LEN_W){1'b0}}, wlen_ff} > WINDOW_MAX) len = CNT_W'(WINDOW_MAX);
      else len = CNT_W'(wlen_ff);
      lenm1 = SLOT_W'(len - CNT_W'(1));
      pos = ({1'b0, slot_ff[mk]} >= len) ? '0 : slot_ff[mk];
      cnt_next = (cnt_ff[mk] < CNT_W'(WINDOW_MAX)) ? cnt_ff[mk] + CNT_W'(1) : cnt_ff[mk];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= LEN_W'(4);
         inv_ff <= 16'hFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: wlen_ff <= csr_wdata[LEN_W-1:0];
            CSR_INVALID_WORD:  inv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MARKERS; i++) begin
            slot_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.write) begin
         slot_ff[mk] <= (pos == lenm1) ? '0 : pos + SLOT_W'(1);
         cnt_ff[mk] <= cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= req_tdata[2:0];
         det_ff <= req_tdata[3];
         x_ff <= req_tdata[23:4];
         y_ff <= req_tdata[43:24];
         a_ff <= req_tdata[59:44];
         full_ff <= 1'b0;
      end else if (cmd.write) begin
         xmem[{mk, pos}] <= x_ff;
         ymem[{mk, pos}] <= y_ff;
         amem[{mk, pos}] <= a_ff;
         full_ff <= cnt_next >= len;
      end
   end

   // memory read: address issued in ST_SUM, data registered in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.sum_clr) begin
         ridx_ff <= '0;
         rd_en_ff <= 1'b0;
         xs_ff <= '0; ys_ff <= '0; as_ff <= '0;
      end else begin
         rd_en_ff <= cmd.sum_step && (ridx_ff < len);
         if (cmd.sum_step) ridx_ff <= ridx_ff + 1'b1;
         if (rd_en_ff) begin
            xs_ff <= xs_ff + SUMP_W'(signed'(xr_ff));
            ys_ff <= ys_ff + SUMP_W'(signed'(yr_ff));
            as_ff <= as_ff + SUMA_W'(signed'(ar_ff));
         end
      end
      xr_ff <= xmem[{mk, ridx_ff[SLOT_W-1:0]}];
      yr_ff <= ymem[{mk, ridx_ff[SLOT_W-1:0]}];
      ar_ff <= amem[{mk, ridx_ff[SLOT_W-1:0]}];
   end

   assign sts.eligible  = elig;
   assign sts.full      = full_ff;
   // one extra step drains the read latency
   assign sts.last_slot = ({1'b0, ridx_ff} == {1'b0, len});
   assign sts.div_done  = (bit_ff == 7'd0);

   always_comb begin
      rxs = {rx_ff[QDIV_W-2:0], nx_ff[QDIV_W-1]};
      rys = {ry_ff[QDIV_W-2:0], ny_ff[QDIV_W-1]};
      ras = {ra_ff[QDIV_W-2:0], na_ff[QDIV_W-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PROD_W'(as_ff) * signed'({1'b0, RAD_TO_DEG_Q16});
      if (cmd.div_start) begin
         sx_ff <= xs_ff[SUMP_W-1];
         sy_ff <= ys_ff[SUMP_W-1];
         sa_ff <= prod_ff[PROD_W-1];
         nx_ff <= QDIV_W'(xs_ff[SUMP_W-1] ? -xs_ff : xs_ff);
         ny_ff <= QDIV_W'(ys_ff[SUMP_W-1] ? -ys_ff : ys_ff);
         na_ff <= QDIV_W'(prod_ff[PROD_W-1] ? -prod_ff : prod_ff);
         rx_ff <= '0; ry_ff <= '0; ra_ff <= '0;
         dpos_ff <= QDIV_W'(len) << 4;
         dang_ff <= QDIV_W'(len) << 29;
         bit_ff <= 7'(QDIV_W - 1);
      end else if (cmd.div_step) begin
         nx_ff <= {nx_ff[QDIV_W-2:0], (rxs >= dpos_ff)};
         rx_ff <= (rxs >= dpos_ff) ? rxs - dpos_ff : rxs;
         ny_ff <= {ny_ff[QDIV_W-2:0], (rys >= dpos_ff)};
         ry_ff <= (rys >= dpos_ff) ? rys - dpos_ff : rys;
         na_ff <= {na_ff[QDIV_W-2:0], (ras >= dang_ff)};
         ra_ff <= (ras >= dang_ff) ? ras - dang_ff : ras;
         bit_ff <= bit_ff - 7'd1;
      end
      if (cmd.fin) begin
         vres_ff <= elig && full_ff;
         if (elig && full_ff) begin
            // quotient bits shift into n after the last step
            xw_ff <= sx_ff ? nx_ff[15:0] : 16'(-nx_ff);
            yw_ff <= sy_ff ? 16'(-ny_ff) : ny_ff[15:0];
            aw_ff <= sa_ff ? 16'(-na_ff) : na_ff[15:0];
         end else begin
            xw_ff <= inv_ff; yw_ff <= inv_ff; aw_ff <= inv_ff;
         end
      end
   end

   assign rsp_tdata = {4'b0, vres_ff, aw_ff, yw_ff, xw_ff, id_ff};
endmodule
